@@ rtl/upq_pkg.sv @@
// Shared types and constants of the unsorted-array min-priority queue.
package upq_pkg;

    localparam int ID_W   = 32;
    localparam int PRIO_W = 16;
    localparam int SEQ_W  = 32;
    localparam int CMP_W  = 32;
    localparam int OCC_W  = 7;

    typedef enum logic [1:0] {
        ACT_INSERT  = 2'd0,
        ACT_PEEK    = 2'd1,
        ACT_EXTRACT = 2'd2,
        ACT_CLEAR   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_EXHAUSTED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } t_state;

    typedef struct packed {
        t_status           status;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [SEQ_W-1:0]  seq;
        logic [CMP_W-1:0]  cmp;
        logic [OCC_W-1:0]  occ;
    } t_result;

endpackage

@@ rtl/unsorted_array_min_priority_queue.sv @@
// Top level of the unsorted-array min-priority queue with stream ports.
//
// Bounded min-priority queue of up to CAPACITY entries kept unsorted in one
// synchronous memory. Each item on the slave stream carries an action in
// s_axis_tuser (0 insert, 1 peek minimum, 2 extract minimum, 3 clear the
// comparison counter) and, for insert, an id and a priority in s_axis_tdata.
// Every item gives exactly one result on the master stream. Insert, clear and
// any request that fails (full, empty, sequence exhausted) go from acceptance
// straight to the response state. Peek and extract read the stored entries
// through the memory's single read port, one per cycle, before responding.
// Among equal priorities the earlier arrival wins. Extract moves the last
// entry into the hole during the final scan cycle. One item is in work at a
// time; a finished result sits in an output register, so the next item is
// accepted while the previous result still waits on m_axis_tready. Memory
// contents are not cleared at reset; only entries below the current occupancy
// are ever used.
module unsorted_array_min_priority_queue #(
    parameter int CAPACITY      = 64,
    parameter int PRIORITY_BITS = 16,
    parameter int SEQUENCE_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,  // new_id[31:0], new_priority[47:32]
    input  logic [1:0]   s_axis_tuser,  // action[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata,  // out_id[31:0], out_priority[47:32],
                                        // out_sequence[79:48],
                                        // comparisons_made[111:80],
                                        // occupancy[118:112], zero pad[119]
    output logic [1:0]   m_axis_tuser   // status[1:0]
);
    import upq_pkg::*;

    // priorities wider than the port field cannot occur
    localparam int PW = (PRIORITY_BITS < PRIO_W) ? PRIORITY_BITS : PRIO_W;
    localparam int SW = SEQUENCE_BITS;
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RW = ID_W + PW + SW;

    logic          w_in_ok;
    logic          w_ready;
    logic          w_res_valid;
    logic          w_res_ready;
    t_result       w_res;
    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    logic [RW-1:0] w_ram_wdata;
    logic          w_ram_re;
    logic [AW-1:0] w_ram_raddr;
    logic [RW-1:0] w_ram_rdata;

    // output holding register
    logic          r_out_valid;
    t_result       r_out;

    assign s_axis_tready = w_ready;
    assign w_in_ok       = s_axis_tvalid && w_ready;

    // the holding register frees up in the same cycle it drains
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {1'b0, r_out.occ, r_out.cmp, r_out.seq, r_out.prio, r_out.id};

    upq_ctrl #(
        .CAPACITY (CAPACITY),
        .PW       (PW),
        .SW       (SW),
        .AW       (AW),
        .RW       (RW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_in_ok),
        .o_ready     (w_ready),
        .i_action    (t_action'(s_axis_tuser)),
        .i_id        (s_axis_tdata[31:0]),
        .i_prio      (s_axis_tdata[47:32]),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    upq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (RW),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result lost or changed under backpressure");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && r_out_valid && !m_axis_tready) |-> !w_res_ready)
        else $error("result would overwrite a pending one");

    a_in_res_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_ok |-> !w_res_valid)
        else $error("item accepted while the sequencer holds a result");

endmodule

@@ rtl/upq_ram.sv @@
// Simple dual-port entry memory, one write and one registered read port.
module upq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 80,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/upq_ctrl.sv @@
// Queue sequencer: insert, linear minimum scan, hole fill and counters.
module upq_ctrl #(
    parameter int CAPACITY = 64,
    parameter int PW       = 16,
    parameter int SW       = 32,
    parameter int AW       = 6,
    parameter int RW       = 80
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  upq_pkg::t_action              i_action,
    input  logic [upq_pkg::ID_W-1:0]      i_id,
    input  logic [upq_pkg::PRIO_W-1:0]    i_prio,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output upq_pkg::t_result              o_res,
    output logic                          o_ram_we,
    output logic [AW-1:0]                 o_ram_waddr,
    output logic [RW-1:0]                 o_ram_wdata,
    output logic                          o_ram_re,
    output logic [AW-1:0]                 o_ram_raddr,
    input  logic [RW-1:0]                 i_ram_rdata
);
    import upq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [SW-1:0]   r_arrival, n_arrival;
    logic [CMP_W-1:0] r_total, n_total;
    logic            r_extract, n_extract;
    t_status         r_status, n_status;
    logic [AW-1:0]   r_didx, n_didx;
    logic [AW-1:0]   r_best_idx, n_best_idx;
    logic [ID_W-1:0] r_best_id, n_best_id;
    logic [PW-1:0]   r_best_prio, n_best_prio;
    logic [SW-1:0]   r_best_seq, n_best_seq;

    logic [ID_W-1:0] w_d_id;
    logic [PW-1:0]   w_d_prio;
    logic [SW-1:0]   w_d_seq;
    logic [CW-1:0]   w_last;
    logic            w_take;
    logic            w_scan_end;
    logic [AW-1:0]   w_fin_idx;
    logic [CMP_W:0]  w_sum;
    logic            w_full;
    logic            w_exhausted;
    logic [PW+PRIO_W-1:0] w_prio_ext;
    logic [SW+SEQ_W-1:0]  w_seq_ext;
    logic [CW+OCC_W-1:0]  w_occ_ext;

    // record layout, lowest bits first: sequence, priority, id
    assign w_d_seq  = i_ram_rdata[SW-1:0];
    assign w_d_prio = i_ram_rdata[SW+PW-1:SW];
    assign w_d_id   = i_ram_rdata[RW-1:SW+PW];

    assign w_last      = r_count - CW'(1);
    assign w_scan_end  = (CW'(r_didx) == w_last);
    assign w_take      = (r_didx == '0) || (w_d_prio < r_best_prio) ||
                         ((w_d_prio == r_best_prio) && (w_d_seq < r_best_seq));
    assign w_fin_idx   = w_take ? r_didx : r_best_idx;
    assign w_sum       = {1'b0, r_total} + (CMP_W+1)'(w_last);
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_exhausted = (r_arrival == '1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_arrival <= '0;
            r_total   <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_arrival <= n_arrival;
            r_total   <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_extract   <= n_extract;
        r_status    <= n_status;
        r_didx      <= n_didx;
        r_best_idx  <= n_best_idx;
        r_best_id   <= n_best_id;
        r_best_prio <= n_best_prio;
        r_best_seq  <= n_best_seq;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_arrival   = r_arrival;
        n_total     = r_total;
        n_extract   = r_extract;
        n_status    = r_status;
        n_didx      = r_didx;
        n_best_idx  = r_best_idx;
        n_best_id   = r_best_id;
        n_best_prio = r_best_prio;
        n_best_seq  = r_best_seq;
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_count[AW-1:0];
        o_ram_wdata = {i_id, i_prio[PW-1:0], r_arrival};
        o_ram_re    = 1'b0;
        o_ram_raddr = '0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_didx      = '0;
                    n_best_idx  = '0;
                    n_best_id   = '0;
                    n_best_prio = '0;
                    n_best_seq  = '0;
                    n_status    = ST_OK;
                    n_state     = S_RESP;
                    case (i_action)
                        ACT_INSERT: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else if (w_exhausted) begin
                                n_status = ST_EXHAUSTED;
                            end else begin
                                o_ram_we  = 1'b1;
                                n_count   = r_count + CW'(1);
                                n_arrival = r_arrival + SW'(1);
                            end
                        end
                        ACT_PEEK, ACT_EXTRACT: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                // entry 0 is fetched now; the count is charged up front
                                o_ram_re  = 1'b1;
                                n_extract = (i_action == ACT_EXTRACT);
                                n_total   = w_sum[CMP_W] ? '1 : w_sum[CMP_W-1:0];
                                n_state   = S_SCAN;
                            end
                        end
                        ACT_CLEAR: begin
                            n_total = '0;
                        end
                        default: begin
                            n_total = r_total;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // data on the read port belongs to entry r_didx
                o_ram_re    = 1'b1;
                o_ram_raddr = r_didx + AW'(1);
                n_didx      = r_didx + AW'(1);
                if (w_take) begin
                    n_best_idx  = r_didx;
                    n_best_id   = w_d_id;
                    n_best_prio = w_d_prio;
                    n_best_seq  = w_d_seq;
                end
                if (w_scan_end) begin
                    n_state = S_RESP;
                    if (r_extract) begin
                        // last entry is on the read port: move it into the hole
                        o_ram_we    = (w_fin_idx != r_didx);
                        o_ram_waddr = w_fin_idx;
                        o_ram_wdata = i_ram_rdata;
                        n_count     = w_last;
                        if (w_last == '0) begin
                            n_arrival = '0;
                        end
                    end
                end
            end
            S_RESP: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_prio_ext   = {{PRIO_W{1'b0}}, r_best_prio};
    assign w_seq_ext    = {{SEQ_W{1'b0}}, r_best_seq};
    assign w_occ_ext    = {{OCC_W{1'b0}}, r_count};
    assign o_res.status = r_status;
    assign o_res.id     = r_best_id;
    assign o_res.prio   = w_prio_ext[PRIO_W-1:0];
    assign o_res.seq    = w_seq_ext[SEQ_W-1:0];
    assign o_res.cmp    = r_total;
    assign o_res.occ    = w_occ_ext[OCC_W-1:0];

    a_arrival_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_arrival == '0))
        else $error("arrival counter not restarted with queue empty");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid && i_action == ACT_INSERT && !w_full && !w_exhausted)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("successful insert did not grow the queue");

    a_scan_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> (r_count == $past(r_count)) ||
                                (r_count == $past(r_count) - CW'(1)))
        else $error("scan changed occupancy by more than one");

    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> ((r_state == S_IDLE && i_valid) || r_state == S_SCAN))
        else $error("entry write outside insert or hole fill");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_res_valid))
        else $error("new item taken while a result is pending");

endmodule

@@ dv/unsorted_array_min_priority_queue_tb.sv @@
// Self-checking testbench for the unsorted-array min-priority queue.
`timescale 1ns / 1ps

module unsorted_array_min_priority_queue_tb;

    import upq_pkg::*;

    localparam int DEPTH       = 64;
    localparam int STALL_LIMIT = 3000;  // cycles with no handshake on either side
    localparam int DRAIN_WAIT  = 80;    // full scan of 64 plus response slack
    localparam int PHASE_ITEMS = 433;   // items in each of three phases of random traffic

    // Scoreboard: mirrors the queue contents, predicts one result per
    // accepted request and checks results in order.
    class pq_scoreboard;
        logic [ID_W-1:0]   slot_id   [DEPTH];
        logic [PRIO_W-1:0] slot_prio [DEPTH];
        logic [SEQ_W-1:0]  slot_seq  [DEPTH];
        int                stored;
        logic [SEQ_W-1:0]  arrival_next;
        logic [CMP_W-1:0]  compare_count;
        t_result           pending_results[$];
        int                mismatches;
        int                results_seen;

        function new();
            stored        = 0;
            arrival_next  = '0;
            compare_count = '0;
            mismatches    = 0;
            results_seen  = 0;
        endfunction

        // Apply one request to the mirror and queue the result it must give.
        function void note_request(t_action act, logic [ID_W-1:0] id,
                                   logic [PRIO_W-1:0] pr);
            t_result r;
            int      best;
            int      last;
            r        = '0;
            r.status = ST_OK;
            case (act)
                ACT_INSERT: begin
                    if (stored >= DEPTH) begin
                        r.status = ST_FULL;
                    end else if (arrival_next == '1) begin
                        r.status = ST_EXHAUSTED;
                    end else begin
                        slot_id[stored]   = id;
                        slot_prio[stored] = pr;
                        slot_seq[stored]  = arrival_next;
                        stored++;
                        arrival_next++;
                    end
                end
                ACT_PEEK, ACT_EXTRACT: begin
                    if (stored == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        best = 0;
                        for (int i = 1; i < stored; i++) begin
                            if (compare_count != '1)
                                compare_count++;
                            // lower priority wins, equal priority goes to earlier arrival
                            if (slot_prio[i] < slot_prio[best] ||
                                (slot_prio[i] == slot_prio[best] &&
                                 slot_seq[i] < slot_seq[best]))
                                best = i;
                        end
                        r.id   = slot_id[best];
                        r.prio = slot_prio[best];
                        r.seq  = slot_seq[best];
                        if (act == ACT_EXTRACT) begin
                            last            = stored - 1;
                            slot_id[best]   = slot_id[last];
                            slot_prio[best] = slot_prio[last];
                            slot_seq[best]  = slot_seq[last];
                            stored          = last;
                            if (stored == 0)
                                arrival_next = '0;
                        end
                    end
                end
                default: begin
                    compare_count = '0;
                end
            endcase
            r.cmp = compare_count;
            r.occ = OCC_W'(stored);
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string what, logic [SEQ_W-1:0] got, logic [SEQ_W-1:0] want);
            mismatches++;
            $display("[%0t] result %0d: %s mismatch, got 0x%0h, expected 0x%0h",
                     $time, results_seen, what, got, want);
        endtask

        task check_result(t_result seen);
            t_result want;
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result status", SEQ_W'(seen.status), '0);
            end else begin
                want = pending_results.pop_front();
                if (seen.status != want.status)
                    report_mismatch("status", SEQ_W'(seen.status), SEQ_W'(want.status));
                if (seen.id != want.id)
                    report_mismatch("out_id", seen.id, want.id);
                if (seen.prio != want.prio)
                    report_mismatch("out_priority", SEQ_W'(seen.prio), SEQ_W'(want.prio));
                if (seen.seq != want.seq)
                    report_mismatch("out_sequence", seen.seq, want.seq);
                if (seen.cmp != want.cmp)
                    report_mismatch("comparisons", seen.cmp, want.cmp);
                if (seen.occ != want.occ)
                    report_mismatch("occupancy", SEQ_W'(seen.occ), SEQ_W'(want.occ));
            end
        endtask
    endclass

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata  = '0;   // new_id[31:0], new_priority[47:32]
    logic [1:0]   s_axis_tuser  = '0;   // action[1:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [119:0] m_axis_tdata;         // out_id, out_priority, out_sequence,
                                        // comparisons_made, occupancy, pad
    logic [1:0]   m_axis_tuser;         // status[1:0]

    pq_scoreboard sb = new();

    int  src_idle_pct  = 0;   // chance per cycle that the sender holds off
    int  sink_idle_pct = 0;   // chance per cycle that the receiver stalls
    int  stall_cycles  = 0;
    bit  filling       = 1'b1;  // random traffic leans to inserts while set

    unsorted_array_min_priority_queue u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver: ready is redrawn every falling edge.
    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Result monitor and watchdog, both on the rising edge.
    always @(posedge i_clk) begin
        t_result seen;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen.status = t_status'(m_axis_tuser);
                seen.id     = m_axis_tdata[31:0];
                seen.prio   = m_axis_tdata[47:32];
                seen.seq    = m_axis_tdata[79:48];
                seen.cmp    = m_axis_tdata[111:80];
                seen.occ    = m_axis_tdata[118:112];
                sb.check_result(seen);
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Present one request at a falling edge, hold it until the handshake,
    // then hand it to the scoreboard. Valid only drops during a hold-off.
    task automatic send_item(t_action act, logic [ID_W-1:0] id, logic [PRIO_W-1:0] pr);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {pr, id};
        s_axis_tuser  = act;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(act, id, pr);
        @(negedge i_clk);
    endtask

    // Random traffic swings between filling and draining the queue so that
    // both full and empty are hit repeatedly; priorities crowd into a few
    // values half of the time to force tie-breaks on arrival order.
    task automatic send_random_item();
        int                roll;
        int                pick;
        t_action           act;
        logic [PRIO_W-1:0] pr;
        if (sb.stored == DEPTH) filling = 1'b0;
        if (sb.stored == 0)     filling = 1'b1;
        if ($urandom_range(0, 99) < 2) filling = !filling;
        roll = $urandom_range(0, 99);
        if (filling)
            act = (roll < 70) ? ACT_INSERT : (roll < 80) ? ACT_PEEK :
                  (roll < 96) ? ACT_EXTRACT : ACT_CLEAR;
        else
            act = (roll < 15) ? ACT_INSERT : (roll < 30) ? ACT_PEEK :
                  (roll < 96) ? ACT_EXTRACT : ACT_CLEAR;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            pr = PRIO_W'($urandom_range(0, 3));
        else if (pick < 60)
            pr = $urandom_range(0, 1) ? '1 : '0;
        else
            pr = PRIO_W'($urandom_range(0, 65535));
        send_item(act, $urandom, pr);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // phase 1: occasional sender gaps, heavy receiver back-pressure
        src_idle_pct  = 7;
        sink_idle_pct = 68;

        // directed: empty queue, single entry, extremes, ties, counter clear
        send_item(ACT_PEEK,    '0, '0);
        send_item(ACT_EXTRACT, '0, '0);
        send_item(ACT_CLEAR,   '1, '1);
        send_item(ACT_INSERT,  32'h7FFF_FFFF, 16'hFFFF);
        send_item(ACT_PEEK,    '0, '0);
        send_item(ACT_EXTRACT, '0, '0);   // empties queue, arrival count restarts
        send_item(ACT_INSERT,  32'h8000_0000, 16'h0000);
        send_item(ACT_INSERT,  32'h0000_0000, 16'h0000);
        send_item(ACT_INSERT,  32'hFFFF_FFFF, 16'hFFFF);
        send_item(ACT_INSERT,  32'h0000_0001, 16'h0000);
        send_item(ACT_PEEK,    '0, '0);
        send_item(ACT_EXTRACT, '0, '0);   // last entry moves into the hole
        send_item(ACT_EXTRACT, '0, '0);
        send_item(ACT_CLEAR,   '0, '0);
        send_item(ACT_PEEK,    '0, '0);
        send_item(ACT_EXTRACT, '0, '0);
        send_item(ACT_EXTRACT, '0, '0);
        send_item(ACT_EXTRACT, '0, '0);   // already empty
        send_item(ACT_INSERT,  32'h5555_5555, 16'hAAAA);
        send_item(ACT_INSERT,  32'hAAAA_AAAA, 16'h5555);
        send_item(ACT_PEEK,    '0, '0);
        send_item(ACT_EXTRACT, '0, '0);
        send_item(ACT_EXTRACT, '0, '0);

        repeat (PHASE_ITEMS) send_random_item();

        // phase 2: sender mostly idle, receiver rarely stalls
        src_idle_pct  = 68;
        sink_idle_pct = 7;
        repeat (PHASE_ITEMS) send_random_item();

        // phase 3: back to back on both sides
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        repeat (PHASE_ITEMS) send_random_item();

        s_axis_tvalid = 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        // watch for stray results after the last expected one
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
